// ===== rtl/core/tml_pkg.sv =====
package tml_pkg;

    localparam int SUM_W  = 48;
    localparam int ROOT_W = 25;
    localparam int LOSS_W = 31;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_SUM  = 2'd1;

    localparam logic [0:0] REG_MARGIN = 1'b0;
    localparam logic [0:0] REG_MODE   = 1'b1;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // vector-end request passed from front to back
    typedef struct packed {
        logic [SUM_W-1:0] pos_sum;
        logic [SUM_W-1:0] neg_sum;
        logic             last_vector;
    } tml_vec_t;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

// ===== rtl/core/triplet_margin_loss_unit.sv =====
// Triplet margin loss unit. One (anchor, positive, negative) element triple is
// taken per cycle and squared distances are summed in a two-stage front end.
// At a vector's end the sums go through a one-entry queue to the back end,
// which takes both square roots one bit per cycle, forms the hinge loss, and
// in mean mode divides by the vector count one bit per cycle. The back end
// takes a new vector end only once it is idle again, after emitting or
// accumulating the last one. Elements stream at one per cycle except when a
// vector's last element waits in stage 1 while the queue is still full.
// Loss is unsigned Q23.8, saturated.
module triplet_margin_loss_unit
    import tml_pkg::*;
#(
    parameter int MAX_VECTORS = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // anchor_val, positive_val, negative_val
    input  logic        s_axis_tlast,  // last_element
    input  logic        s_axis_tuser,  // last_vector
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // loss, pad bit
    output logic        m_axis_tuser,  // is_batch_total
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CNT_W = $clog2(MAX_VECTORS + 1);

    logic        margin_wr;
    logic [15:0] margin_val_reg;
    logic [1:0]  mode_reg;
    logic        q_valid, q_ready;
    tml_vec_t    q_data;
    logic [LOSS_W-1:0] loss;

    assign cfg_ready = 1'b1;
    assign margin_wr = cfg_valid && cfg_index == REG_MARGIN;
    assign m_axis_tdata = {1'b0, loss};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_val_reg <= 16'd256;
            mode_reg       <= MODE_NONE;
        end
        else if (margin_wr)
            margin_val_reg <= cfg_data;
        else if (cfg_valid && cfg_index == REG_MODE)
            mode_reg <= cfg_data[1:0];
    end

    tml_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .a            (s_axis_tdata[15:0]),
        .p            (s_axis_tdata[31:16]),
        .n            (s_axis_tdata[47:32]),
        .last_element (s_axis_tlast),
        .last_vector  (s_axis_tuser),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_data       (q_data)
    );

    tml_back #(
        .CNT_W   (CNT_W),
        .MAX_VEC (MAX_VECTORS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_data         (q_data),
        .margin         (margin_val_reg),
        .mode           (mode_reg),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .loss           (loss),
        .is_batch_total (m_axis_tuser)
    );

endmodule

// ===== rtl/core/tml_front.sv =====
module tml_front
    import tml_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [15:0]    a,
    input  logic [15:0]    p,
    input  logic [15:0]    n,
    input  logic           last_element,
    input  logic           last_vector,
    output logic           q_valid,
    input  logic           q_ready,
    output tml_vec_t       q_data
);

    // stage 1: squared differences registered; stage 2: accumulate
    logic             s1_valid_reg;
    logic [33:0]      sq_p_reg, sq_n_reg;
    logic             s1_le_reg, s1_lv_reg;
    logic [SUM_W-1:0] pos_reg, neg_reg;
    logic             out_valid_reg;
    tml_vec_t         out_reg;
    logic signed [16:0] dp, dn;
    logic [16:0]      mp, mn;
    logic [SUM_W-1:0] pos_next, neg_next;
    logic             stall;

    assign stall    = out_valid_reg && !q_ready && s1_valid_reg && s1_le_reg;
    assign in_ready = !stall;
    assign q_valid  = out_valid_reg;
    assign q_data   = out_reg;

    always_comb
    begin
        dp = $signed({a[15], a}) - $signed({p[15], p});
        dn = $signed({a[15], a}) - $signed({n[15], n});
        mp = dp[16] ? 17'(-dp) : 17'(dp);
        mn = dn[16] ? 17'(-dn) : 17'(dn);
        pos_next = sat_add(pos_reg, {14'd0, sq_p_reg});
        neg_next = sat_add(neg_reg, {14'd0, sq_n_reg});
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            sq_p_reg  <= 34'(mp * mp);
            sq_n_reg  <= 34'(mn * mn);
            s1_le_reg <= last_element;
            s1_lv_reg <= last_vector;
        end
        if (!stall && s1_valid_reg && s1_le_reg)
        begin
            out_reg.pos_sum     <= pos_next;
            out_reg.neg_sum     <= neg_next;
            out_reg.last_vector <= s1_lv_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            neg_reg       <= '0;
        end
        else
        begin
            if (!stall && s1_valid_reg && s1_le_reg)
                out_valid_reg <= 1'b1;
            else if (q_ready)
                out_valid_reg <= 1'b0;
            if (!stall)
            begin
                s1_valid_reg <= in_valid;
                if (s1_valid_reg)
                begin
                    if (s1_le_reg)
                    begin
                        pos_reg <= '0;
                        neg_reg <= '0;
                    end
                    else
                    begin
                        pos_reg <= pos_next;
                        neg_reg <= neg_next;
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/core/tml_back.sv =====
module tml_back
    import tml_pkg::*;
#(
    parameter int CNT_W   = 17,
    parameter int MAX_VEC = 65536
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  tml_vec_t          q_data,
    input  logic [15:0]       margin,
    input  logic [1:0]        mode,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [LOSS_W-1:0] loss,
    output logic              is_batch_total
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_ROOT = 6'b000010,
        ST_LOSS = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_EMIT = 6'b010000,
        ST_ACC  = 6'b100000
    } st_t;

    st_t              st_reg;
    // sum plus epsilon can reach 2^48, so the radicand carries two extra bits
    logic [SUM_W+1:0] vp_reg, vn_reg;
    logic [SUM_W-1:0] rem_p_reg, rem_n_reg;
    logic [ROOT_W-1:0] rp_reg, rn_reg;
    logic [4:0]       step_reg;
    logic             lv_reg;
    logic [SUM_W-1:0] total_reg, vloss_reg;
    logic [CNT_W-1:0] count_reg;
    logic [SUM_W-1:0] quo_reg, rem_reg;
    logic [5:0]       dstep_reg;
    logic [LOSS_W-1:0] loss_reg;
    logic             batch_reg;

    // restoring square root, one result bit per cycle for both roots
    logic [SUM_W+1:0] trial_p, trial_n, win_p, win_n;
    logic [SUM_W+1:0] rem_shift;
    logic signed [26:0] diff;
    logic [SUM_W-1:0] total_next;
    logic [SUM_W:0]   dv;

    always_comb
    begin
        win_p   = {rem_p_reg, vp_reg[2*step_reg+1 -: 2]};
        win_n   = {rem_n_reg, vn_reg[2*step_reg+1 -: 2]};
        trial_p = {{(SUM_W-ROOT_W){1'b0}}, rp_reg, 2'b01};
        trial_n = {{(SUM_W-ROOT_W){1'b0}}, rn_reg, 2'b01};
        diff = $signed({2'b0, rp_reg}) - $signed({2'b0, rn_reg})
             + 27'($signed(margin));
        total_next = sat_add(total_reg, vloss_reg);
        rem_shift = {1'b0, rem_reg, quo_reg[SUM_W-1]};
        dv = rem_shift[SUM_W:0] - {{(SUM_W-CNT_W+1){1'b0}}, count_reg};
    end

    assign q_ready        = st_reg == ST_IDLE;
    assign out_valid      = st_reg == ST_EMIT;
    assign loss           = loss_reg;
    assign is_batch_total = batch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            total_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            case (st_reg)
                ST_IDLE:
                    if (q_valid)
                    begin
                        vp_reg    <= {2'b00, q_data.pos_sum} + 50'd1;
                        vn_reg    <= {2'b00, q_data.neg_sum} + 50'd1;
                        lv_reg    <= q_data.last_vector;
                        rem_p_reg <= '0;
                        rem_n_reg <= '0;
                        rp_reg    <= '0;
                        rn_reg    <= '0;
                        step_reg  <= 5'd24;
                        st_reg    <= ST_ROOT;
                    end
                ST_ROOT:
                begin
                    if (win_p >= trial_p)
                    begin
                        rem_p_reg <= SUM_W'(win_p - trial_p);
                        rp_reg    <= {rp_reg[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_p_reg <= SUM_W'(win_p);
                        rp_reg    <= {rp_reg[ROOT_W-2:0], 1'b0};
                    end
                    if (win_n >= trial_n)
                    begin
                        rem_n_reg <= SUM_W'(win_n - trial_n);
                        rn_reg    <= {rn_reg[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_n_reg <= SUM_W'(win_n);
                        rn_reg    <= {rn_reg[ROOT_W-2:0], 1'b0};
                    end
                    if (step_reg == 5'd0)
                        st_reg <= ST_LOSS;
                    step_reg <= step_reg - 5'd1;
                end
                ST_LOSS:
                begin
                    vloss_reg <= diff[26] ? '0 : SUM_W'(diff[25:0]);
                    if (mode == MODE_NONE)
                    begin
                        loss_reg  <= diff[26] ? '0 : LOSS_W'(diff[25:0]);
                        batch_reg <= 1'b0;
                        st_reg    <= ST_EMIT;
                    end
                    else
                        st_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (!lv_reg)
                    begin
                        total_reg <= total_next;
                        if (count_reg < CNT_W'(MAX_VEC))
                            count_reg <= count_reg + 1'b1;
                        st_reg <= ST_IDLE;
                    end
                    else
                    begin
                        batch_reg <= 1'b1;
                        total_reg <= '0;
                        if (mode == MODE_SUM)
                        begin
                            count_reg <= '0;
                            loss_reg <= (|total_next[SUM_W-1:LOSS_W]) ? '1
                                      : total_next[LOSS_W-1:0];
                            st_reg <= ST_EMIT;
                        end
                        else
                        begin
                            quo_reg   <= total_next;
                            rem_reg   <= '0;
                            dstep_reg <= '0;
                            if (count_reg < CNT_W'(MAX_VEC))
                                count_reg <= count_reg + 1'b1;
                            st_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    // restoring divide by count, one quotient bit per cycle
                    if (!dv[SUM_W])
                    begin
                        rem_reg <= dv[SUM_W-1:0];
                        quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_shift[SUM_W-1:0];
                        quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
                    end
                    dstep_reg <= dstep_reg + 1'b1;
                    if (dstep_reg == 6'(SUM_W-1))
                    begin
                        count_reg <= '0;
                        st_reg    <= ST_EMIT;
                        if (|quo_reg[SUM_W-2:LOSS_W-1])
                            loss_reg <= '1;
                        else
                            loss_reg <= {quo_reg[LOSS_W-2:0], !dv[SUM_W]};
                    end
                end
                ST_EMIT:
                    if (out_ready)
                        st_reg <= ST_IDLE;
                default:
                    st_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
